[rtl/core/pfb_pkg.sv]
package pfb_pkg;

    // default geometry
    localparam int DEF_PAGE_COUNT   = 8;
    localparam int DEF_COLUMN_COUNT = 128;

    // stream payload widths
    localparam int S_TDATA_W = 24;  // page_index, column_index, image_byte, zero fill
    localparam int S_TUSER_W = 2;   // req_type
    localparam int M_TDATA_W = 8;   // read_data
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // request kinds
    localparam logic [1:0] REQ_CLEAR_ALL = 2'd0;
    localparam logic [1:0] REQ_CLEAR_RECT = 2'd1;
    localparam logic [1:0] REQ_BLIT = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    // register indexes
    localparam logic [1:0] REG_DEST_X = 2'd0;
    localparam logic [1:0] REG_DEST_Y = 2'd1;
    localparam logic [1:0] REG_AREA_WIDTH = 2'd2;
    localparam logic [1:0] REG_AREA_HEIGHT = 2'd3;

    // memory port address / data selection
    localparam logic [2:0] SEL_SWEEP = 3'd0;
    localparam logic [2:0] SEL_RECT = 3'd1;
    localparam logic [2:0] SEL_BLIT0 = 3'd2;
    localparam logic [2:0] SEL_BLIT1 = 3'd3;
    localparam logic [2:0] SEL_READ = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       mem_rd;
        logic       mem_wr;
        logic [2:0] sel;
        logic       sweep_step;
        logic       rect_next;
        logic       out_load;
    } pfb_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       rect_empty;
        logic       blit_skip;
        logic       blit_spill;
        logic       rect_last;
        logic       sweep_last;
        logic       out_free;
    } pfb_stat_t;

endpackage

[rtl/core/page_framebuffer_blit.sv]
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser req_type, tdata page/column/byte
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata read_data
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// Accepting edge to result in the output register: read fetches the byte; blit
// reads then writes the target byte, and on a spill the byte in the next page;
// rectangle clear does so for each byte walked; clear all writes every byte; a
// skipped blit or empty rectangle goes straight to the result. The frame store
// is single-port. After reset a clearing pass zeroes it one byte a cycle; requests
// wait for it, config writes do not. A full output register stalls the last step.
module page_framebuffer_blit #(
    parameter int PAGE_COUNT   = pfb_pkg::DEF_PAGE_COUNT,
    parameter int COLUMN_COUNT = pfb_pkg::DEF_COLUMN_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] page_index, [9:3] column_index, [17:10] image_byte, [23:18] zero
    input  logic [pfb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [pfb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] read_data
    output logic [pfb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // register writes: 0 dest_x, 1 dest_y, 2 area_width, 3 area_height
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfb_pkg::CFG_DAT_W-1:0] cfg_data
);
    import pfb_pkg::*;

    pfb_cmd_t  cmd;
    pfb_stat_t stat;

    // sequencer: one request at a time
    pfb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // registers, frame store, address and mask logic, output slot
    pfb_dpath #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[rtl/core/pfb_ctrl.sv]
module pfb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  pfb_pkg::pfb_stat_t stat,
    output pfb_pkg::pfb_cmd_t  cmd
);
    import pfb_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SWEEP = 4'd2;
    localparam logic [3:0] S_RRD   = 4'd3;
    localparam logic [3:0] S_RWR   = 4'd4;
    localparam logic [3:0] S_BRD0  = 4'd5;
    localparam logic [3:0] S_BWR0  = 4'd6;
    localparam logic [3:0] S_BRD1  = 4'd7;
    localparam logic [3:0] S_BWR1  = 4'd8;
    localparam logic [3:0] S_MRD   = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.sel = SEL_SWEEP;
        case (state_reg)
            S_INIT:
            begin
                cmd.mem_wr = 1'b1;
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    case (stat.req_type)
                        REQ_CLEAR_ALL:  state_next = S_SWEEP;
                        REQ_CLEAR_RECT: state_next = stat.rect_empty ? S_RESP : S_RRD;
                        REQ_BLIT:       state_next = stat.blit_skip ? S_RESP : S_BRD0;
                        default:        state_next = S_MRD;
                    endcase
                end
            end
            S_SWEEP:
            begin
                cmd.mem_wr = 1'b1;
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_RESP;
            end
            S_RRD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.sel = SEL_RECT;
                state_next = S_RWR;
            end
            S_RWR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.sel = SEL_RECT;
                cmd.rect_next = 1'b1;
                state_next = stat.rect_last ? S_RESP : S_RRD;
            end
            S_BRD0:
            begin
                cmd.mem_rd = 1'b1;
                cmd.sel = SEL_BLIT0;
                state_next = S_BWR0;
            end
            S_BWR0:
            begin
                cmd.mem_wr = 1'b1;
                cmd.sel = SEL_BLIT0;
                state_next = stat.blit_spill ? S_BRD1 : S_RESP;
            end
            S_BRD1:
            begin
                cmd.mem_rd = 1'b1;
                cmd.sel = SEL_BLIT1;
                state_next = S_BWR1;
            end
            S_BWR1:
            begin
                cmd.mem_wr = 1'b1;
                cmd.sel = SEL_BLIT1;
                state_next = S_RESP;
            end
            S_MRD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.sel = SEL_READ;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/pfb_dpath.sv]
module pfb_dpath #(
    parameter int PAGE_COUNT   = pfb_pkg::DEF_PAGE_COUNT,
    parameter int COLUMN_COUNT = pfb_pkg::DEF_COLUMN_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfb_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic [pfb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [pfb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pfb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  pfb_pkg::pfb_cmd_t             cmd,
    output pfb_pkg::pfb_stat_t            stat
);
    import pfb_pkg::*;

    localparam int ROW_COUNT  = PAGE_COUNT * 8;
    localparam int STORE_SIZE = PAGE_COUNT * COLUMN_COUNT;
    localparam int AW         = $clog2(STORE_SIZE);

    function automatic logic [AW-1:0] addr_of(input logic [3:0] pg, input logic [7:0] cl);
        addr_of = AW'(32'(pg) * COLUMN_COUNT + 32'(cl));
    endfunction

    // configuration
    logic [6:0] dest_x_reg;
    logic [5:0] dest_y_reg;
    logic [7:0] area_width_reg;
    logic [6:0] area_height_reg;

    // request fields
    logic [2:0] page_in;
    logic [6:0] col_in;
    logic [7:0] byte_in;

    // decode
    logic        origin_ok;
    logic [8:0]  x_sum, x_end, x_last;
    logic [7:0]  y_sum, y_end, y_last;
    logic [7:0]  col_t;
    logic [3:0]  page_t;
    logic [15:0] shifted;
    logic        read_ok;
    logic [3:0]  req_page;
    logic [7:0]  req_col;

    // captured request
    logic [AW-1:0] req_addr_reg;
    logic          spill_reg;
    logic [7:0]    lo_reg, hi_reg;
    logic          read_flag_reg;

    // rectangle walk
    logic [3:0] page_reg, page_first_reg, page_last_reg;
    logic [7:0] col_reg, col_first_reg, col_last_reg;
    logic [2:0] bit_first_reg, bit_last_reg;
    logic [2:0] bit_lo, bit_hi;
    logic [7:0] keep;
    logic [AW-1:0] rect_addr;

    // memory
    logic [7:0]    mem [STORE_SIZE];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] sweep_reg;
    logic          sweep_last;

    // output slot
    logic       out_valid_reg;
    logic [7:0] out_data_reg;

    assign page_in = s_axis_tdata[2:0];
    assign col_in  = s_axis_tdata[9:3];
    assign byte_in = s_axis_tdata[17:10];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            area_width_reg  <= '0;
            area_height_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEST_X:      dest_x_reg      <= cfg_data[6:0];
                REG_DEST_Y:      dest_y_reg      <= cfg_data[5:0];
                REG_AREA_WIDTH:  area_width_reg  <= cfg_data[7:0];
                REG_AREA_HEIGHT: area_height_reg <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        origin_ok = (9'(dest_x_reg) < 9'(COLUMN_COUNT)) && (8'(dest_y_reg) < 8'(ROW_COUNT));
        x_sum  = 9'(dest_x_reg) + 9'(area_width_reg);
        x_end  = (x_sum > 9'(COLUMN_COUNT)) ? 9'(COLUMN_COUNT) : x_sum;
        x_last = x_end - 9'd1;
        y_sum  = 8'(dest_y_reg) + 8'(area_height_reg);
        y_end  = (y_sum > 8'(ROW_COUNT)) ? 8'(ROW_COUNT) : y_sum;
        y_last = y_end - 8'd1;
        col_t  = 8'(dest_x_reg) + 8'(col_in);
        page_t = 4'(dest_y_reg[5:3]) + 4'(page_in);
        shifted = 16'(byte_in) << dest_y_reg[2:0];
        read_ok = (5'(page_in) < 5'(PAGE_COUNT)) && (9'(col_in) < 9'(COLUMN_COUNT));
        req_page = (s_axis_tuser == REQ_BLIT) ? page_t : 4'(page_in);
        req_col  = (s_axis_tuser == REQ_BLIT) ? col_t : 8'(col_in);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_addr_reg  <= addr_of(req_page, req_col);
            spill_reg     <= (dest_y_reg[2:0] != 3'd0) &&
                             (5'(page_t) + 5'd1 < 5'(PAGE_COUNT));
            lo_reg        <= shifted[7:0];
            hi_reg        <= shifted[15:8];
            read_flag_reg <= (s_axis_tuser == REQ_READ) && read_ok;
            page_first_reg <= 4'(dest_y_reg[5:3]);
            page_last_reg  <= y_last[6:3];
            bit_first_reg  <= dest_y_reg[2:0];
            bit_last_reg   <= y_last[2:0];
            col_first_reg  <= 8'(dest_x_reg);
            col_last_reg   <= x_last[7:0];
            page_reg       <= 4'(dest_y_reg[5:3]);
            col_reg        <= 8'(dest_x_reg);
        end
        else if (cmd.rect_next)
        begin
            if (col_reg == col_last_reg)
            begin
                col_reg  <= col_first_reg;
                page_reg <= page_reg + 4'd1;
            end
            else
            begin
                col_reg <= col_reg + 8'd1;
            end
        end
    end

    // bits of the current page that a rectangle clear keeps: those outside the rectangle rows
    always_comb
    begin
        bit_lo = (page_reg == page_first_reg) ? bit_first_reg : 3'd0;
        bit_hi = (page_reg == page_last_reg) ? bit_last_reg : 3'd7;
        keep = ~((8'hFF << bit_lo) & (8'hFF >> (3'd7 - bit_hi)));
        rect_addr = addr_of(page_reg, col_reg);
    end

    assign sweep_last = (sweep_reg == AW'(STORE_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.sweep_step)
            sweep_reg <= sweep_last ? '0 : sweep_reg + AW'(1);
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_SWEEP:
            begin
                mem_addr  = sweep_reg;
                mem_wdata = 8'h00;
            end
            SEL_RECT:
            begin
                mem_addr  = rect_addr;
                mem_wdata = rdata_reg & keep;
            end
            SEL_BLIT0:
            begin
                mem_addr  = req_addr_reg;
                mem_wdata = rdata_reg | lo_reg;
            end
            SEL_BLIT1:
            begin
                mem_addr  = req_addr_reg + AW'(COLUMN_COUNT);
                mem_wdata = rdata_reg | hi_reg;
            end
            default:
            begin
                mem_addr  = req_addr_reg;
                mem_wdata = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[mem_addr] <= mem_wdata;
        if (cmd.mem_rd)
            rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= read_flag_reg ? rdata_reg : 8'h00;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        stat.req_type   = s_axis_tuser;
        stat.rect_empty = !origin_ok || (area_width_reg == 8'd0) || (area_height_reg == 7'd0);
        stat.blit_skip  = !origin_ok || (9'(col_t) >= 9'(COLUMN_COUNT)) ||
                          (5'(page_t) >= 5'(PAGE_COUNT));
        stat.blit_spill = spill_reg;
        stat.rect_last  = (page_reg == page_last_reg) && (col_reg == col_last_reg);
        stat.sweep_last = sweep_last;
        stat.out_free   = !out_valid_reg || m_axis_tready;
    end

endmodule

[bench/page_framebuffer_blit_test.sv]
`timescale 1ns / 1ps
module page_framebuffer_blit_test;

    import pfb_pkg::*;

    // Screen geometry as built
    localparam int PAGES   = DEF_PAGE_COUNT;
    localparam int COLUMNS = DEF_COLUMN_COUNT;
    localparam int ROWS    = PAGES * 8;

    // Random part: phases of requests, each with its own register setting
    localparam int PHASES        = 20;
    localparam int PHASE_ITEMS   = 100;
    localparam int STALL_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 40;    // quiet time after the last result

    // Directed plan: either a request or a register write
    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] code;    // request kind or register index
        logic [2:0] page;
        logic [6:0] col;
        logic [7:0] value;   // image byte or register data
        bit         typed;   // expected byte given in the row
        logic [7:0] want;
    } plan_row_t;

    typedef struct {
        logic [7:0] data;
        int         seq;
    } pending_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // Shadow copy of the frame store and the registers
    logic [7:0] frame_model [PAGES*COLUMNS];
    logic [6:0] reg_dest_x;
    logic [5:0] reg_dest_y;
    logic [7:0] reg_area_width;
    logic [6:0] reg_area_height;

    pending_byte_t pending_bytes [$];
    plan_row_t     plan [$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_asked;
    int stall_seen;
    int stall_left;
    int req_seq;
    int mismatches;
    int results_seen;
    int settings_used;
    int kind_count [4];

    page_framebuffer_blit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Hard stop, well beyond the slowest legal run
    initial
    begin
        #50_000_000;
        $display("timeout: %0d results still outstanding", pending_bytes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Register write as the block sees it (field widths only)
    function automatic void apply_register(logic [1:0] idx, logic [7:0] val);
        case (idx)
            REG_DEST_X:      reg_dest_x = val[6:0];
            REG_DEST_Y:      reg_dest_y = val[5:0];
            REG_AREA_WIDTH:  reg_area_width = val;
            REG_AREA_HEIGHT: reg_area_height = val[6:0];
            default: ;
        endcase
    endfunction

    // Applies one request to the shadow store and returns the result byte
    function automatic logic [7:0] frame_request(logic [1:0] kind, logic [2:0] page,
                                                 logic [6:0] col, logic [7:0] pix);
        int         x0, y0, w, h, r, c, tp, tc, sh;
        logic [15:0] wide;
        logic [7:0]  result;
        result = '0;
        x0 = int'(reg_dest_x);
        y0 = int'(reg_dest_y);
        case (kind)
            REQ_CLEAR_ALL:
                foreach (frame_model[i]) frame_model[i] = '0;
            REQ_CLEAR_RECT:
                if (x0 < COLUMNS && y0 < ROWS)
                begin
                    w = int'(reg_area_width);
                    h = int'(reg_area_height);
                    // clamp to the right edge and to the bottom
                    if (x0 + w > COLUMNS) w = COLUMNS - x0;
                    if (y0 + h > ROWS) h = ROWS - y0;
                    for (r = y0; r < y0 + h; r++)
                        for (c = x0; c < x0 + w; c++)
                            frame_model[(r / 8) * COLUMNS + c] &= ~(8'h01 << (r % 8));
                end
            REQ_BLIT:
                if (x0 < COLUMNS && y0 < ROWS)
                begin
                    tc = x0 + int'(col);
                    tp = y0 / 8 + int'(page);
                    sh = y0 % 8;
                    if (tc < COLUMNS && tp < PAGES)
                    begin
                        wide = {8'h00, pix} << sh;
                        frame_model[tp * COLUMNS + tc] |= wide[7:0];
                        // spill into the page below, unless that is off the bottom
                        if (sh != 0 && tp + 1 < PAGES)
                            frame_model[(tp + 1) * COLUMNS + tc] |= wide[15:8];
                    end
                end
            default:
                if (int'(page) < PAGES && int'(col) < COLUMNS)
                    result = frame_model[int'(page) * COLUMNS + int'(col)];
        endcase
        return result;
    endfunction

    // Offer one request; returns on the accepting edge
    task automatic send_request(logic [1:0] kind, logic [2:0] page, logic [6:0] col,
                                logic [7:0] pix, bit typed, logic [7:0] want);
        pending_byte_t entry;
        logic [7:0]    got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'b0, pix, col, page};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = frame_request(kind, page, col, pix);
        entry.data = typed ? want : got;
        entry.seq  = req_seq++;
        pending_bytes.push_back(entry);
        kind_count[kind]++;
    endtask

    // Stop offering and wait for every expected result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void req_row(logic [1:0] kind, logic [2:0] page, logic [6:0] col,
                                    logic [7:0] pix);
        plan.push_back('{ROW_REQ, kind, page, col, pix, 1'b0, 8'h00});
    endfunction

    function automatic void chk_row(logic [1:0] kind, logic [2:0] page, logic [6:0] col,
                                    logic [7:0] pix, logic [7:0] want);
        plan.push_back('{ROW_REQ, kind, page, col, pix, 1'b1, want});
    endfunction

    function automatic void cfg_row(logic [1:0] idx, logic [7:0] val);
        plan.push_back('{ROW_CFG, idx, 3'd0, 7'd0, val, 1'b0, 8'h00});
    endfunction

    // Receiver: random back-pressure, plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (stall_seen != stall_asked)
        begin
            stall_seen = stall_asked;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: oldest expectation first
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_bytes.size() == 0)
                report_error($sformatf("result %02h with no request outstanding", m_axis_tdata));
            else if (m_axis_tdata !== pending_bytes[0].data)
            begin
                report_error($sformatf("request %0d: read_data %02h, expected %02h",
                                       pending_bytes[0].seq, m_axis_tdata,
                                       pending_bytes[0].data));
                void'(pending_bytes.pop_front());
            end
            else
                void'(pending_bytes.pop_front());
        end
    end

    initial
    begin
        int         ph, n, pick, last_page, last_col, rect_pct, tp, tc;
        bit         big_rects;
        logic [1:0] kind;
        logic [2:0] page;
        logic [6:0] col;
        logic [7:0] val;

        foreach (frame_model[i]) frame_model[i] = '0;
        reg_dest_x = '0;
        reg_dest_y = '0;
        reg_area_width = '0;
        reg_area_height = '0;
        send_idle_pct = 24;
        recv_idle_pct = 87;
        stall_asked = 0;
        stall_seen = 0;
        stall_left = 0;
        req_seq = 0;
        mismatches = 0;
        results_seen = 0;
        settings_used = 1;
        kind_count = '{default: 0};
        last_page = 0;
        last_col = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed plan ---
        // fresh store reads zero at both corners
        chk_row(REQ_READ, 3'd0, 7'd0, 8'h00, 8'h00);
        chk_row(REQ_READ, 3'd7, 7'd127, 8'hFF, 8'h00);
        // aligned blits at the two corners, no shift
        chk_row(REQ_BLIT, 3'd0, 7'd0, 8'hFF, 8'h00);
        chk_row(REQ_READ, 3'd0, 7'd0, 8'h00, 8'hFF);
        chk_row(REQ_BLIT, 3'd7, 7'd127, 8'h80, 8'h00);
        chk_row(REQ_READ, 3'd7, 7'd127, 8'h00, 8'h80);
        // bottom page with shift: spill dropped, then right/bottom overrun skipped
        cfg_row(REG_DEST_X, 8'd120);
        cfg_row(REG_DEST_Y, 8'd61);
        req_row(REQ_BLIT, 3'd0, 7'd7, 8'hFF);
        req_row(REQ_READ, 3'd7, 7'd127, 8'h00);
        req_row(REQ_BLIT, 3'd1, 7'd0, 8'hFF);
        req_row(REQ_BLIT, 3'd0, 7'd8, 8'hFF);
        req_row(REQ_READ, 3'd7, 7'd0, 8'h00);
        // mid-screen blit spilling into the next page
        cfg_row(REG_DEST_X, 8'd0);
        cfg_row(REG_DEST_Y, 8'd3);
        req_row(REQ_BLIT, 3'd2, 7'd5, 8'hA5);
        req_row(REQ_READ, 3'd2, 7'd5, 8'h00);
        req_row(REQ_READ, 3'd3, 7'd5, 8'h00);
        // oversized rectangle clamped at the corner; image byte ignored
        cfg_row(REG_DEST_X, 8'd100);
        cfg_row(REG_DEST_Y, 8'd60);
        cfg_row(REG_AREA_WIDTH, 8'd255);
        cfg_row(REG_AREA_HEIGHT, 8'd127);
        chk_row(REQ_CLEAR_RECT, 3'd7, 7'd127, 8'hFF, 8'h00);
        req_row(REQ_READ, 3'd7, 7'd127, 8'h00);
        // zero width clears nothing
        cfg_row(REG_AREA_WIDTH, 8'd0);
        cfg_row(REG_AREA_HEIGHT, 8'd10);
        chk_row(REQ_CLEAR_RECT, 3'd0, 7'd0, 8'h00, 8'h00);
        req_row(REQ_READ, 3'd2, 7'd5, 8'hFF);
        // far corner origin: one-pixel blit and one-pixel clear
        cfg_row(REG_DEST_X, 8'd127);
        cfg_row(REG_DEST_Y, 8'd63);
        cfg_row(REG_AREA_WIDTH, 8'd128);
        cfg_row(REG_AREA_HEIGHT, 8'd64);
        req_row(REQ_BLIT, 3'd0, 7'd0, 8'hFF);
        req_row(REQ_READ, 3'd7, 7'd127, 8'h00);
        req_row(REQ_CLEAR_RECT, 3'd0, 7'd0, 8'h00);
        req_row(REQ_READ, 3'd7, 7'd127, 8'h00);
        // full clear leaves nothing behind
        chk_row(REQ_CLEAR_ALL, 3'd5, 7'd99, 8'h5A, 8'h00);
        chk_row(REQ_READ, 3'd0, 7'd0, 8'h00, 8'h00);
        chk_row(REQ_READ, 3'd3, 7'd5, 8'h00, 8'h00);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(plan[i].code, plan[i].value);
                settings_used++;
            end
            else
                send_request(plan[i].code, plan[i].page, plan[i].col, plan[i].value,
                             plan[i].typed, plan[i].want);
        end
        drain_results();

        // --- random phases ---
        for (ph = 0; ph < PHASES; ph++)
        begin
            // sender 24 / receiver 87, then swapped, then no idling
            if (ph < 7)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 87;
            end
            else if (ph < 14)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // new setting, extremes weighted in; big rectangles only now and then
            big_rects = (ph % 8 == 3);
            pick = $urandom_range(99);
            val = (pick < 25) ? 8'd0 : (pick < 40) ? 8'd127 : 8'($urandom_range(127));
            write_reg(REG_DEST_X, val);
            pick = $urandom_range(99);
            val = (pick < 25) ? 8'd0 : (pick < 40) ? 8'd63 : 8'($urandom_range(63));
            write_reg(REG_DEST_Y, val);
            if (big_rects)
            begin
                write_reg(REG_AREA_WIDTH, 8'($urandom_range(255)));
                write_reg(REG_AREA_HEIGHT, 8'($urandom_range(127)));
            end
            else
            begin
                // wide request at the right edge still clamps to a few columns
                val = (reg_dest_x > 7'd115) ? 8'd255 : 8'($urandom_range(12));
                write_reg(REG_AREA_WIDTH, val);
                write_reg(REG_AREA_HEIGHT, 8'($urandom_range(12)));
            end
            settings_used++;
            rect_pct = big_rects ? 3 : 9;

            // one long hold-off so the block backs up and stalls its input
            if (ph == 1)
                stall_asked++;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                page = 3'($urandom_range(7));
                col  = 7'($urandom_range(127));
                val  = 8'($urandom_range(255));
                if (pick < 1)
                    kind = REQ_CLEAR_ALL;
                else if (pick < 1 + rect_pct)
                    kind = REQ_CLEAR_RECT;
                else if (pick < 55)
                begin
                    kind = REQ_BLIT;
                    // mostly small image coordinates so the blit lands on screen
                    if ($urandom_range(99) < 70)
                    begin
                        page = 3'($urandom_range(1));
                        col  = 7'($urandom_range(15));
                    end
                    tp = int'(reg_dest_y) / 8 + int'(page);
                    tc = int'(reg_dest_x) + int'(col);
                    if (tp < PAGES && tc < COLUMNS)
                    begin
                        last_page = tp;
                        last_col  = tc;
                    end
                end
                else
                begin
                    kind = REQ_READ;
                    // revisit the last blit target or the page it spilled into
                    if ($urandom_range(99) < 60)
                    begin
                        tp = last_page + $urandom_range(1);
                        page = 3'((tp < PAGES) ? tp : last_page);
                        col  = 7'(last_col);
                    end
                end
                send_request(kind, page, col, val, 1'b0, 8'h00);
            end
            // sender waits here for every result before the next setting
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d blits, %0d reads, %0d rectangle clears, %0d full clears",
                 req_seq, kind_count[REQ_BLIT], kind_count[REQ_READ],
                 kind_count[REQ_CLEAR_RECT], kind_count[REQ_CLEAR_ALL]);
        $display("Across %0d register settings; %0d results checked, %0d mismatches",
                 settings_used, results_seen, mismatches);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
